// ===== src/isolated_pixel_removal_3x3_assert.svh =====
// assertion macros shared by the rtl files
`ifndef ISOLATED_PIXEL_REMOVAL_3X3_ASSERT_SVH
`define ISOLATED_PIXEL_REMOVAL_3X3_ASSERT_SVH

// property must hold at every clock edge out of reset
`define IPR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define IPR_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/ipr_pkg.sv =====
package ipr_pkg;

	localparam int ROW_W = 64;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] MAX_ROW_PIXELS = 7'd64;
	localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd64;

	typedef logic [ROW_W-1:0] row_t;

	// one queue entry: results of one input row
	typedef struct packed {
		row_t row_a;    // the row one above, last_out 0
		logic a_valid;
		row_t row_b;    // the final row, last_out 1
		logic b_valid;
	} ipr_entry_t;

	function automatic row_t width_mask(input logic [CFG_W-1:0] w);
		logic [CFG_W-1:0] w_eff;
		row_t m;
		w_eff = (w > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : w;
		for (int i = 0; i < ROW_W; i++) begin
			m[i] = (w_eff > CFG_W'(i));
		end
		return m;
	endfunction

	function automatic row_t spread(input row_t r);
		return r | (r << 1) | (r >> 1);
	endfunction

	// keep a set pixel only if some 8-neighbour is set
	function automatic row_t clean_row(input row_t above, input row_t mid,
		input row_t below, input row_t mask);
		row_t near_px;
		near_px = spread(above) | spread(below) | (mid << 1) | (mid >> 1);
		return mid & near_px & mask;
	endfunction

endpackage

// ===== src/ipr_front.sv =====
module ipr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [ipr_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ipr_pkg::row_t               row_pixels,
	input  logic                        final_row,
	input  logic                        fifo_full,
	output logic                        push,
	output ipr_pkg::ipr_entry_t         push_entry
);

	logic [ipr_pkg::CFG_W-1:0] width_q;
	ipr_pkg::row_t earlier_q;
	ipr_pkg::row_t held_q;
	logic held_valid_q;

	ipr_pkg::row_t mask;
	ipr_pkg::row_t row_m;
	ipr_pkg::row_t above;
	logic accept;

	assign in_stall = fifo_full;
	assign accept = in_valid & ~fifo_full;

	always_comb begin
		mask = ipr_pkg::width_mask(width_q);
		row_m = row_pixels & mask;
		above = held_valid_q ? (held_q & mask) : '0;
		push_entry.row_a = ipr_pkg::clean_row(earlier_q & mask, held_q & mask, row_m, mask);
		push_entry.a_valid = held_valid_q;
		push_entry.row_b = ipr_pkg::clean_row(above, row_m, '0, mask);
		push_entry.b_valid = final_row;
	end

	// first row of an image gives nothing to queue unless it is also the final row
	assign push = accept & (held_valid_q | final_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ipr_pkg::WIDTH_RESET;
			earlier_q <= '0;
			held_q <= '0;
			held_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				width_q <= cfg_data;
			end
			if (accept) begin
				if (final_row) begin
					earlier_q <= '0;
					held_q <= '0;
					held_valid_q <= 1'b0;
				end else begin
					earlier_q <= above;
					held_q <= row_m;
					held_valid_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/ipr_fifo.sv =====
module ipr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ipr_pkg::ipr_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output ipr_pkg::ipr_entry_t head,
	output logic                not_empty
);

	ipr_pkg::ipr_entry_t slot_q [2];
	logic [1:0] count_q;
	logic wr_ptr_q;
	logic rd_ptr_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`include "isolated_pixel_removal_3x3_assert.svh"

	`IPR_NEVER(a_push_full, push && full, "queue written while full")
	`IPR_NEVER(a_pop_empty, pop && !not_empty, "queue read while empty")
	`IPR_ASSERT(a_push_has_result, push |-> (push_entry.a_valid || push_entry.b_valid), "queued entry carries no result")

endmodule

// ===== src/ipr_back.sv =====
module ipr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ipr_pkg::ipr_entry_t head,
	input  logic                not_empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output ipr_pkg::row_t       filtered_row,
	output logic                last_out
);

	logic out_valid_q;
	ipr_pkg::row_t out_row_q;
	logic out_last_q;
	logic pend_valid_q;
	ipr_pkg::row_t pend_row_q;
	logic load;

	// output register is free or being taken this cycle
	assign load = ~out_valid_q | ~out_stall;
	assign pop = load & ~pend_valid_q & not_empty;

	assign out_valid = out_valid_q;
	assign filtered_row = out_row_q;
	assign last_out = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (not_empty) begin
				out_valid_q <= 1'b1;
				pend_valid_q <= head.a_valid & head.b_valid;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_row_q <= pend_row_q;
				out_last_q <= 1'b1;
			end else if (not_empty) begin
				pend_row_q <= head.row_b;
				if (head.a_valid) begin
					out_row_q <= head.row_a;
					out_last_q <= 1'b0;
				end else begin
					out_row_q <= head.row_b;
					out_last_q <= 1'b1;
				end
			end
		end
	end

`include "isolated_pixel_removal_3x3_assert.svh"

	`IPR_ASSERT(a_pend_behind_out, pend_valid_q |-> out_valid_q, "pending final row without row ahead of it")

endmodule

// ===== src/isolated_pixel_removal_3x3.sv =====
// isolated_pixel_removal_3x3: clears every set pixel of a binary image that has
// none of its eight neighbours set. rows come in one 64-bit word per item
// (bit n = column n), final_row marks the last row of an image. a row leaves one
// input later, since its verdict needs the row below; the final row's item
// gives two results, the row above it and the final row itself marked last_out
// (a one-row image gives just that row). neighbours outside the image are clear
// and columns at or above row_width read as zero in and out. row_width resets
// to 64, values above 64 act as 64, and the user must write it only while the
// block is idle; the block itself does not enforce this. rate: one row item
// per clock while in_stall is low; the back end sends at most one result per
// clock, so a final row's two results are absorbed by a two-entry queue
// between the classifier and the output stage. an item taken in is written
// into the queue and then into the output register, when that register is
// free and no earlier result waits; the last_out row of a multi-row image
// follows the row above it from a pending register, and a later result waits.
module isolated_pixel_removal_3x3 (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ipr_pkg::CFG_W-1:0] row_width,
	// row input
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [ipr_pkg::ROW_W-1:0] row_pixels,
	input  logic                      final_row,
	// filtered row output
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ipr_pkg::ROW_W-1:0] filtered_row,
	output logic                      last_out
);

	// front to queue
	logic push;
	ipr_pkg::ipr_entry_t push_entry;
	logic fifo_full;
	// queue to back
	logic pop;
	ipr_pkg::ipr_entry_t head;
	logic not_empty;

	// width register always takes a write
	assign cfg_ready = 1'b1;

	// classifier: holds the two rows above and builds each item's results
	ipr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (row_width),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.row_pixels (row_pixels),
		.final_row  (final_row),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// short queue decouples input stalls from output stalls
	ipr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty)
	);

	// output stage: splits an entry into one or two results
	ipr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered_row (filtered_row),
		.last_out     (last_out)
	);

endmodule
